// ----- design/ccpo_pkg.sv -----
package ccpo_pkg;

	// Obstacle kind carried in the input tuser bit.
	typedef enum logic {
		OP_POINT = 1'b0,
		OP_WALL  = 1'b1
	} op_t;

	// Flow control that travels with every stage: request valid and the
	// enable of the operation that the next unit performs.
	typedef struct packed {
		logic vld;
		logic en;
	} flow_t;

endpackage

// ----- design/ccpo_wall.sv -----
module ccpo_wall #(
	parameter int CB     = 32,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  ccpo_pkg::flow_t     flow_i,
	input  logic [CB-1:0]       cv_i,
	input  logic [CB-1:0]       cu_i,
	input  logic [CB-1:0]       fa_i,
	input  logic [CB-1:0]       ua_i,
	input  logic [CB-1:0]       ub_i,
	input  logic [CB-2:0]       r_i,
	input  logic [SIDE_W-1:0]   side_i,
	output ccpo_pkg::flow_t     flow_o,
	output logic [CB-1:0]       cv_o,
	output logic [CB-1:0]       cu_o,
	output logic [SIDE_W-1:0]   side_o
);

	ccpo_pkg::flow_t     flow_s1;
	logic [CB-1:0]       cv_s1;
	logic [CB-1:0]       cu_s1;
	logic [SIDE_W-1:0]   side_s1;

	logic [CB-1:0]       lo;
	logic [CB-1:0]       hi;
	logic                inr;
	logic [CB:0]         diff;
	logic [CB:0]         dmag;
	logic                near;
	logic [CB:0]         sum;
	logic [CB-1:0]       snap_val;
	logic                snap;

	// Span of the wall along its own axis and whether the circle lies in it.
	assign lo  = ($signed(ua_i) < $signed(ub_i)) ? ua_i : ub_i;
	assign hi  = ($signed(ua_i) < $signed(ub_i)) ? ub_i : ua_i;
	assign inr = ($signed(cu_i) >= $signed(lo)) && ($signed(cu_i) <= $signed(hi));

	// Distance across the wall and the snapped coordinate on the circle's side.
	assign diff = {cv_i[CB-1], cv_i} - {fa_i[CB-1], fa_i};
	assign dmag = diff[CB] ? (~diff + 1'b1) : diff;
	assign near = dmag < {2'b00, r_i};
	assign sum  = diff[CB] ? ({fa_i[CB-1], fa_i} - {2'b00, r_i})
	                       : ({fa_i[CB-1], fa_i} + {2'b00, r_i});

	always_comb begin
		if (sum[CB] != sum[CB-1]) begin
			snap_val = sum[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
		end else begin
			snap_val = sum[CB-1:0];
		end
	end

	assign snap = flow_i.en && inr && near;

	// Control register of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_s1 <= '0;
		end else if (adv) begin
			flow_s1.vld <= flow_i.vld;
			flow_s1.en  <= flow_i.en && !inr;
		end
	end

	// Payload register of the stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			cv_s1   <= snap ? snap_val : cv_i;
			cu_s1   <= cu_i;
			side_s1 <= side_i;
		end
	end

	assign flow_o = flow_s1;
	assign cv_o   = cv_s1;
	assign cu_o   = cu_s1;
	assign side_o = side_s1;

endmodule

// ----- design/ccpo_push.sv -----
module ccpo_push #(
	parameter int CB     = 32,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  ccpo_pkg::flow_t     flow_i,
	input  logic [CB-1:0]       cx_i,
	input  logic [CB-1:0]       cz_i,
	input  logic [CB-1:0]       ax_i,
	input  logic [CB-1:0]       az_i,
	input  logic [CB-2:0]       r_i,
	input  logic [SIDE_W-1:0]   side_i,
	output ccpo_pkg::flow_t     flow_o,
	output logic [CB-1:0]       cx_o,
	output logic [CB-1:0]       cz_o,
	output logic [SIDE_W-1:0]   side_o
);

	localparam int RW = CB - 1;
	localparam int PW = 2 * RW;

	typedef struct packed {
		ccpo_pkg::flow_t   f;
		logic              go;
		logic              sx;
		logic              sz;
		logic [CB-1:0]     cx;
		logic [CB-1:0]     cz;
		logic [CB-1:0]     ax;
		logic [CB-1:0]     az;
		logic [RW-1:0]     r;
		logic [SIDE_W-1:0] side;
	} base_t;

	typedef struct packed {
		logic [PW-1:0] n;
		logic [RW:0]   rem;
		logic [RW-1:0] root;
		logic [PW-1:0] nx;
		logic [PW-1:0] nz;
	} sq_t;

	typedef struct packed {
		logic [RW-1:0] d;
		logic [RW-1:0] remx;
		logic [RW-1:0] remz;
		logic [RW-1:0] lox;
		logic [RW-1:0] loz;
		logic [RW-1:0] qx;
		logic [RW-1:0] qz;
	} dv_t;

	function automatic logic [CB-1:0] sat(input logic [CB+1:0] v);
		logic [CB-1:0] res;
		if ((v[CB+1:CB-1] == 3'b000) || (v[CB+1:CB-1] == 3'b111)) begin
			res = v[CB-1:0];
		end else begin
			res = v[CB+1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
		end
		return res;
	endfunction

	base_t         base_s1, base_s2, base_rd, base_fn;
	base_t         base_sq [RW+1];
	base_t         base_dv [RW+1];
	logic [RW-1:0] mx_s1, mz_s1;
	logic [PW-1:0] px_s2, pz_s2, rr_s2, nx_s2, nz_s2;
	sq_t           data_sq [RW+1];
	dv_t           data_dv [RW+1];
	logic [RW:0]   qx_rd, qz_rd;
	logic [CB-1:0] cx_fn, cz_fn;

	logic [CB:0]   dx, dz, mx, mz;
	logic          near;
	logic [PW:0]   d2;
	base_t         b3;

	// Stage 1: offsets from the point and the quick box reject.
	assign dx   = {cx_i[CB-1], cx_i} - {ax_i[CB-1], ax_i};
	assign dz   = {cz_i[CB-1], cz_i} - {az_i[CB-1], az_i};
	assign mx   = dx[CB] ? (~dx + 1'b1) : dx;
	assign mz   = dz[CB] ? (~dz + 1'b1) : dz;
	assign near = flow_i.en && (mx < {2'b00, r_i}) && (mz < {2'b00, r_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_s1 <= '0;
		end else if (adv) begin
			base_s1.f    <= flow_i;
			base_s1.go   <= near;
			base_s1.sx   <= dx[CB];
			base_s1.sz   <= dz[CB];
			base_s1.cx   <= cx_i;
			base_s1.cz   <= cz_i;
			base_s1.ax   <= ax_i;
			base_s1.az   <= az_i;
			base_s1.r    <= r_i;
			base_s1.side <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1 <= mx[RW-1:0];
			mz_s1 <= mz[RW-1:0];
		end
	end

	// Stage 2: squares and the numerators of the push offsets.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_s2 <= '0;
		end else if (adv) begin
			base_s2 <= base_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2 <= PW'(mx_s1) * PW'(mx_s1);
			pz_s2 <= PW'(mz_s1) * PW'(mz_s1);
			rr_s2 <= PW'(base_s1.r) * PW'(base_s1.r);
			nx_s2 <= PW'(base_s1.r) * PW'(mx_s1);
			nz_s2 <= PW'(base_s1.r) * PW'(mz_s1);
		end
	end

	// Stage 3: squared distance and the exact overlap test.
	assign d2 = {1'b0, px_s2} + {1'b0, pz_s2};

	always_comb begin
		b3    = base_s2;
		b3.go = base_s2.go && (d2 < {1'b0, rr_s2}) && (d2 != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_sq[0] <= '0;
		end else if (adv) begin
			base_sq[0] <= b3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_sq[0].n    <= d2[PW-1:0];
			data_sq[0].rem  <= '0;
			data_sq[0].root <= '0;
			data_sq[0].nx   <= nx_s2;
			data_sq[0].nz   <= nz_s2;
		end
	end

	// Square root, one root bit per stage.
	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [RW+2:0] rsh;
		logic [RW+2:0] trial;
		logic [RW+2:0] sub;
		logic          ge;

		assign rsh   = {data_sq[k].rem, data_sq[k].n[PW-1 -: 2]};
		assign trial = {1'b0, data_sq[k].root, 2'b01};
		assign sub   = rsh - trial;
		assign ge    = rsh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				base_sq[k+1] <= '0;
			end else if (adv) begin
				base_sq[k+1] <= base_sq[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				data_sq[k+1].n    <= {data_sq[k].n[PW-3:0], 2'b00};
				data_sq[k+1].rem  <= ge ? sub[RW:0] : rsh[RW:0];
				data_sq[k+1].root <= {data_sq[k].root[RW-2:0], ge};
				data_sq[k+1].nx   <= data_sq[k].nx;
				data_sq[k+1].nz   <= data_sq[k].nz;
			end
		end
	end

	// Divider setup: the upper half of each numerator is below the distance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_dv[0] <= '0;
		end else if (adv) begin
			base_dv[0] <= base_sq[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_dv[0].d    <= data_sq[RW].root;
			data_dv[0].remx <= data_sq[RW].nx[PW-1:RW];
			data_dv[0].remz <= data_sq[RW].nz[PW-1:RW];
			data_dv[0].lox  <= data_sq[RW].nx[RW-1:0];
			data_dv[0].loz  <= data_sq[RW].nz[RW-1:0];
			data_dv[0].qx   <= '0;
			data_dv[0].qz   <= '0;
		end
	end

	// Two restoring dividers side by side, one quotient bit per stage.
	for (genvar j = 0; j < RW; j++) begin : g_div
		logic [RW:0] rshx, rshz, subx, subz, dext;
		logic        gex, gez;

		assign dext = {1'b0, data_dv[j].d};
		assign rshx = {data_dv[j].remx, data_dv[j].lox[RW-1]};
		assign rshz = {data_dv[j].remz, data_dv[j].loz[RW-1]};
		assign subx = rshx - dext;
		assign subz = rshz - dext;
		assign gex  = rshx >= dext;
		assign gez  = rshz >= dext;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				base_dv[j+1] <= '0;
			end else if (adv) begin
				base_dv[j+1] <= base_dv[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				data_dv[j+1].d    <= data_dv[j].d;
				data_dv[j+1].remx <= gex ? subx[RW-1:0] : rshx[RW-1:0];
				data_dv[j+1].remz <= gez ? subz[RW-1:0] : rshz[RW-1:0];
				data_dv[j+1].lox  <= {data_dv[j].lox[RW-2:0], 1'b0};
				data_dv[j+1].loz  <= {data_dv[j].loz[RW-2:0], 1'b0};
				data_dv[j+1].qx   <= {data_dv[j].qx[RW-2:0], gex};
				data_dv[j+1].qz   <= {data_dv[j].qz[RW-2:0], gez};
			end
		end
	end

	// Round half up on the final remainders.
	logic incx, incz;
	assign incx = {1'b0, data_dv[RW].remx} >=
	              ({1'b0, data_dv[RW].d} - {1'b0, data_dv[RW].remx});
	assign incz = {1'b0, data_dv[RW].remz} >=
	              ({1'b0, data_dv[RW].d} - {1'b0, data_dv[RW].remz});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_rd <= '0;
		end else if (adv) begin
			base_rd <= base_dv[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qx_rd <= {1'b0, data_dv[RW].qx} + (RW+1)'(incx);
			qz_rd <= {1'b0, data_dv[RW].qz} + (RW+1)'(incz);
		end
	end

	// Place the centre at the rounded offset from the point, saturated.
	logic [CB+1:0] ax_e, az_e, qx_e, qz_e, sumx, sumz;
	assign ax_e = {{2{base_rd.ax[CB-1]}}, base_rd.ax};
	assign az_e = {{2{base_rd.az[CB-1]}}, base_rd.az};
	assign qx_e = {2'b00, qx_rd};
	assign qz_e = {2'b00, qz_rd};
	assign sumx = base_rd.sx ? (ax_e - qx_e) : (ax_e + qx_e);
	assign sumz = base_rd.sz ? (az_e - qz_e) : (az_e + qz_e);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_fn <= '0;
		end else if (adv) begin
			base_fn <= base_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_fn <= base_rd.go ? sat(sumx) : base_rd.cx;
			cz_fn <= base_rd.go ? sat(sumz) : base_rd.cz;
		end
	end

	assign flow_o = base_fn.f;
	assign cx_o   = cx_fn;
	assign cz_o   = cz_fn;
	assign side_o = base_fn.side;

endmodule

// ----- design/circle_collision_push_out.sv -----
// Channel  Direction  tdata                                        tuser
// s_*      in         obj_x obj_z radius end_a_x/z end_b_x/z        op
// m_*      out        new_x new_z                                  moved
//
// One request is taken per clock while the output is not stalled; results leave in
// order through the two wall units and the four chained point push units, each
// push unit with one stage per square root bit and per quotient bit.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
module circle_collision_push_out #(
	parameter int COORD_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// obj_x, obj_z, radius, end_a_x, end_a_z, end_b_x, end_b_z (lowest first)
	input  logic [((7*COORD_BITS-1+7)/8)*8-1:0]    s_tdata,
	// op
	input  logic                                   s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// new_x, new_z (lowest first)
	output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,
	// moved
	output logic                                   m_tuser
);

	localparam int CB    = COORD_BITS;
	localparam int OUT_W = ((2*CB+7)/8)*8;

	typedef struct packed {
		logic [CB-1:0]     ox;
		logic [CB-1:0]     oz;
		logic [CB-1:0]     ax;
		logic [CB-1:0]     az;
		logic [CB-1:0]     bx;
		logic [CB-1:0]     bz;
		logic [CB-2:0]     r;
		ccpo_pkg::op_t     op;
		logic              vert;
		logic              horz;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

	logic            adv;
	side_t           side_in, wv_side, pa1_side, pb1_side, wh_side, pa2_side, pb2_side;
	logic [SIDE_W-1:0] wv_sv, pa1_sv, pb1_sv, wh_sv, pa2_sv, pb2_sv;
	ccpo_pkg::flow_t fl_in, wv_fl, pa1_in, pa1_fl, pb1_in, pb1_fl;
	ccpo_pkg::flow_t wh_in, wh_fl, pa2_fl, pb2_fl;
	logic [CB-1:0]   wv_x, wv_z, pa1_x, pa1_z, pb1_x, pb1_z;
	logic [CB-1:0]   wh_z, wh_x, pa2_x, pa2_z, pb2_x, pb2_z;

	logic            m_tvalid_q;
	logic [CB-1:0]   new_x_q, new_z_q;
	logic            moved_q;

	// Pipeline advances unless a finished result is waiting.
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;

	// Unpack the request.
	assign side_in.ox   = s_tdata[CB-1:0];
	assign side_in.oz   = s_tdata[2*CB-1:CB];
	assign side_in.r    = s_tdata[3*CB-2:2*CB];
	assign side_in.ax   = s_tdata[4*CB-2:3*CB-1];
	assign side_in.az   = s_tdata[5*CB-2:4*CB-1];
	assign side_in.bx   = s_tdata[6*CB-2:5*CB-1];
	assign side_in.bz   = s_tdata[7*CB-2:6*CB-1];
	assign side_in.op   = ccpo_pkg::op_t'(s_tuser);
	assign side_in.vert = side_in.ax == side_in.bx;
	assign side_in.horz = side_in.az == side_in.bz;

	// Vertical wall test: push across x, span along z.
	assign fl_in.vld = s_tvalid;
	assign fl_in.en  = (side_in.op == ccpo_pkg::OP_WALL) && side_in.vert;

	ccpo_wall #(.CB(CB), .SIDE_W(SIDE_W)) u_wall_v (
		.clk(clk), .arst_n(arst_n), .adv(adv), .flow_i(fl_in),
		.cv_i(side_in.ox), .cu_i(side_in.oz), .fa_i(side_in.ax),
		.ua_i(side_in.az), .ub_i(side_in.bz), .r_i(side_in.r), .side_i(side_in),
		.flow_o(wv_fl), .cv_o(wv_x), .cu_o(wv_z), .side_o(wv_sv)
	);
	assign wv_side = wv_sv;

	// Push against end A: the point obstacle, or the first end of a wall.
	assign pa1_in.vld = wv_fl.vld;
	assign pa1_in.en  = wv_fl.en || (wv_side.op == ccpo_pkg::OP_POINT);

	ccpo_push #(.CB(CB), .SIDE_W(SIDE_W)) u_push_a1 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .flow_i(pa1_in),
		.cx_i(wv_x), .cz_i(wv_z), .ax_i(wv_side.ax), .az_i(wv_side.az),
		.r_i(wv_side.r), .side_i(wv_sv),
		.flow_o(pa1_fl), .cx_o(pa1_x), .cz_o(pa1_z), .side_o(pa1_sv)
	);
	assign pa1_side = pa1_sv;

	// Push against end B, walls only.
	assign pb1_in.vld = pa1_fl.vld;
	assign pb1_in.en  = pa1_fl.en && (pa1_side.op == ccpo_pkg::OP_WALL);

	ccpo_push #(.CB(CB), .SIDE_W(SIDE_W)) u_push_b1 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .flow_i(pb1_in),
		.cx_i(pa1_x), .cz_i(pa1_z), .ax_i(pa1_side.bx), .az_i(pa1_side.bz),
		.r_i(pa1_side.r), .side_i(pa1_sv),
		.flow_o(pb1_fl), .cx_o(pb1_x), .cz_o(pb1_z), .side_o(pb1_sv)
	);
	assign pb1_side = pb1_sv;

	// Horizontal wall test on the updated position: push across z.
	assign wh_in.vld = pb1_fl.vld;
	assign wh_in.en  = (pb1_side.op == ccpo_pkg::OP_WALL) && pb1_side.horz;

	ccpo_wall #(.CB(CB), .SIDE_W(SIDE_W)) u_wall_h (
		.clk(clk), .arst_n(arst_n), .adv(adv), .flow_i(wh_in),
		.cv_i(pb1_z), .cu_i(pb1_x), .fa_i(pb1_side.az),
		.ua_i(pb1_side.ax), .ub_i(pb1_side.bx), .r_i(pb1_side.r), .side_i(pb1_sv),
		.flow_o(wh_fl), .cv_o(wh_z), .cu_o(wh_x), .side_o(wh_sv)
	);
	assign wh_side = wh_sv;

	ccpo_push #(.CB(CB), .SIDE_W(SIDE_W)) u_push_a2 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .flow_i(wh_fl),
		.cx_i(wh_x), .cz_i(wh_z), .ax_i(wh_side.ax), .az_i(wh_side.az),
		.r_i(wh_side.r), .side_i(wh_sv),
		.flow_o(pa2_fl), .cx_o(pa2_x), .cz_o(pa2_z), .side_o(pa2_sv)
	);
	assign pa2_side = pa2_sv;

	ccpo_push #(.CB(CB), .SIDE_W(SIDE_W)) u_push_b2 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .flow_i(pa2_fl),
		.cx_i(pa2_x), .cz_i(pa2_z), .ax_i(pa2_side.bx), .az_i(pa2_side.bz),
		.r_i(pa2_side.r), .side_i(pa2_sv),
		.flow_o(pb2_fl), .cx_o(pb2_x), .cz_o(pb2_z), .side_o(pb2_sv)
	);
	assign pb2_side = pb2_sv;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= pb2_fl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			new_x_q <= pb2_x;
			new_z_q <= pb2_z;
			moved_q <= (pb2_x != pb2_side.ox) || (pb2_z != pb2_side.oz);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({new_z_q, new_x_q});
	assign m_tuser  = moved_q;

	// A zero radius never moves the circle.
	a_zero_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(pb2_fl.vld && (pb2_side.r == '0)) |->
		((pb2_x == pb2_side.ox) && (pb2_z == pb2_side.oz)))
		else $error("zero radius moved the circle");

	// A slanted wall has no effect.
	a_slanted: assert property (@(posedge clk) disable iff (!arst_n)
		(pb2_fl.vld && (pb2_side.op == ccpo_pkg::OP_WALL) &&
		 !pb2_side.vert && !pb2_side.horz) |->
		((pb2_x == pb2_side.ox) && (pb2_z == pb2_side.oz)))
		else $error("slanted wall moved the circle");

	// No result is offered while reset is held.
	a_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result offered during reset");

endmodule

// ----- tb/circle_collision_push_out_tb.sv -----
`timescale 1ns / 100ps

module circle_collision_push_out_tb;

	localparam int  CB         = 32;
	localparam int  LATENCY    = 8*CB+19;
	localparam int  N_RANDOM   = 1730;
	localparam longint CMAX    = 64'sd2147483647;
	localparam longint CMIN    = -64'sd2147483648;

	typedef struct {
		ccpo_pkg::op_t      op;
		logic signed [31:0] ox, oz;
		logic [30:0]       rad;
		logic signed [31:0] ax, az, bx, bz;
	} request_t;

	typedef struct {
		logic [31:0] nx, nz;
		logic        moved;
	} position_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [223:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic         m_tuser;

	request_t  pending_requests[$];
	position_t expected_positions[$];
	int        total_requests;
	int        sent_count;
	int        received_count;
	int        moved_count;
	int        mismatch_cnt;
	int        send_idle_pct;
	int        recv_stall_pct;

	circle_collision_push_out #(.COORD_BITS(CB)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Free-running clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint clamp_coord(input longint v);
		if (v > CMAX)
			return CMAX;
		if (v < CMIN)
			return CMIN;
		return v;
	endfunction

	function automatic longint unsigned magnitude(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// Division rounded half up.
	function automatic longint unsigned div_round(input logic [127:0] n,
			input longint unsigned d);
		logic [127:0] q, rem;
		q   = n / d;
		rem = n % d;
		if (rem >= d - rem)
			q = q + 1;
		return q[63:0];
	endfunction

	// Radial push of the centre away from a point to exactly the radius.
	function automatic void push_from_point(inout longint cx, inout longint cz,
			input longint px, input longint pz, input longint unsigned r);
		longint dx, dz;
		longint unsigned mx, mz, root, cand, offx, offz;
		logic [127:0] dist2;
		dx = cx - px;
		dz = cz - pz;
		mx = magnitude(dx);
		mz = magnitude(dz);
		if (mx >= r || mz >= r)
			return;
		dist2 = 128'(mx) * 128'(mx) + 128'(mz) * 128'(mz);
		if (dist2 >= 128'(r) * 128'(r) || dist2 == 0)
			return;
		root = 0;
		for (int i = 63; i >= 0; i--) begin
			cand = root | (64'd1 << i);
			if (dist2 >= 128'(cand) * 128'(cand))
				root = cand;
		end
		offx = div_round(128'(r) * 128'(mx), root);
		offz = div_round(128'(r) * 128'(mz), root);
		cx = clamp_coord(dx < 0 ? px - longint'(offx) : px + longint'(offx));
		cz = clamp_coord(dz < 0 ? pz - longint'(offz) : pz + longint'(offz));
	endfunction

	// Wall along axis u at coordinate fa of axis v; ends fall back to point pushes.
	function automatic void push_from_wall(inout longint cv, inout longint cu,
			input longint fa, input longint ua, input longint ub,
			input longint av, input longint au, input longint bv, input longint bu,
			input longint unsigned r);
		longint lo, hi, diff;
		lo = (ua < ub) ? ua : ub;
		hi = (ua < ub) ? ub : ua;
		if (cu >= lo && cu <= hi) begin
			diff = cv - fa;
			if (magnitude(diff) < r)
				cv = clamp_coord(diff >= 0 ? fa + longint'(r) : fa - longint'(r));
		end else begin
			push_from_point(cv, cu, av, au, r);
			push_from_point(cv, cu, bv, bu, r);
		end
	endfunction

	function automatic position_t resolve_position(input request_t q);
		position_t res;
		longint cx, cz, ax, az, bx, bz;
		longint unsigned r;
		cx = q.ox;
		cz = q.oz;
		ax = q.ax;
		az = q.az;
		bx = q.bx;
		bz = q.bz;
		r  = q.rad;
		if (q.op == ccpo_pkg::OP_POINT) begin
			push_from_point(cx, cz, ax, az, r);
		end else begin
			if (ax == bx)
				push_from_wall(cx, cz, ax, az, bz, ax, az, bx, bz, r);
			if (az == bz)
				push_from_wall(cz, cx, az, ax, bx, az, ax, bz, bx, r);
		end
		res.nx    = cx[31:0];
		res.nz    = cz[31:0];
		res.moved = (cx != longint'(q.ox)) || (cz != longint'(q.oz));
		return res;
	endfunction

	function automatic logic [31:0] near(input logic [31:0] base, input int unsigned span);
		return base + $urandom_range(2*span) - span;
	endfunction

	function automatic request_t make_request(input ccpo_pkg::op_t op,
			input longint ox, input longint oz, input longint rad,
			input longint ax, input longint az, input longint bx, input longint bz);
		request_t q;
		q.op  = op;
		q.ox  = 32'(ox);
		q.oz  = 32'(oz);
		q.rad = 31'(rad);
		q.ax  = 32'(ax);
		q.az  = 32'(az);
		q.bx  = 32'(bx);
		q.bz  = 32'(bz);
		return q;
	endfunction

	// Random request, mostly a circle close to its obstacle.
	function automatic request_t random_request();
		request_t q;
		int unsigned kind, span;
		q.op  = ccpo_pkg::op_t'($urandom_range(1));
		q.ox  = $urandom;
		q.oz  = $urandom;
		kind  = $urandom_range(9);
		span  = (kind < 7) ? (1 << $urandom_range(4, 20)) : 32'h7fffffff;
		case ($urandom_range(9))
			0:       q.rad = '0;
			1:       q.rad = 31'($urandom);
			default: q.rad = 31'($urandom_range(span));
		endcase
		if (kind == 9) begin
			q.ax = $urandom;
			q.az = $urandom;
			q.bx = $urandom;
			q.bz = $urandom;
			return q;
		end
		q.ax = near(q.ox, span);
		q.az = near(q.oz, span);
		q.bx = near(q.ox, span);
		q.bz = near(q.oz, span);
		case ($urandom_range(4))
			0, 1: q.bx = q.ax;
			2:    q.bz = q.az;
			3: begin
				q.bx = q.ax;
				q.bz = q.az;
			end
			default: ;
		endcase
		return q;
	endfunction

	// Stimulus: directed corner cases, then random requests.
	initial begin
		pending_requests.push_back(make_request(ccpo_pkg::OP_POINT, 0, 0, 65536, 0, 0, 0, 0));
		pending_requests.push_back(make_request(ccpo_pkg::OP_POINT, 100, 0, 65536,
			0, 0, 0, 0));
		pending_requests.push_back(make_request(ccpo_pkg::OP_POINT, -3000, 4000, 65536,
			0, 0, 0, 0));
		pending_requests.push_back(make_request(ccpo_pkg::OP_POINT, 5, 5, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(ccpo_pkg::OP_POINT, 65536, 0, 65536,
			0, 0, 0, 0));
		pending_requests.push_back(make_request(ccpo_pkg::OP_POINT, CMAX - 5, 0, 65536,
			CMAX - 10, 0, 0, 0));
		pending_requests.push_back(make_request(ccpo_pkg::OP_POINT, CMIN + 3, CMIN + 2,
			32'h7fffffff, CMIN + 9, CMIN + 8, 0, 0));
		pending_requests.push_back(make_request(ccpo_pkg::OP_POINT, CMAX, CMAX, 32'h7fffffff,
			CMIN, CMIN, CMAX, CMIN));
		pending_requests.push_back(make_request(ccpo_pkg::OP_POINT, -1, -1, 32'h7fffffff,
			0, 0, -1, -1));
		pending_requests.push_back(make_request(ccpo_pkg::OP_WALL, 100, 50, 1000,
			0, 0, 0, 200));
		pending_requests.push_back(make_request(ccpo_pkg::OP_WALL, -100, 200, 1000,
			0, 0, 0, 200));
		pending_requests.push_back(make_request(ccpo_pkg::OP_WALL, 0, 100, 1000,
			0, 200, 0, 0));
		pending_requests.push_back(make_request(ccpo_pkg::OP_WALL, 30, 220, 1000,
			0, 0, 0, 200));
		pending_requests.push_back(make_request(ccpo_pkg::OP_WALL, 30, -20, 1000,
			0, 0, 0, 200));
		pending_requests.push_back(make_request(ccpo_pkg::OP_WALL, 50, 10, 1000,
			-500, 0, 500, 0));
		pending_requests.push_back(make_request(ccpo_pkg::OP_WALL, 600, -40, 1000,
			-500, 0, 500, 0));
		pending_requests.push_back(make_request(ccpo_pkg::OP_WALL, 10, 20, 1000,
			0, 0, 0, 0));
		pending_requests.push_back(make_request(ccpo_pkg::OP_WALL, 10, 20, 1000,
			0, 0, 300, 300));
		pending_requests.push_back(make_request(ccpo_pkg::OP_WALL, CMAX - 1, 5, 32'h7fffffff,
			CMAX - 2, 0, CMAX - 2, 10));
		pending_requests.push_back(make_request(ccpo_pkg::OP_WALL, CMIN, CMAX, 32'h7fffffff,
			CMIN + 1, CMAX, CMAX, CMAX));
		pending_requests.push_back(make_request(ccpo_pkg::OP_WALL, 0, 0, 0, 0, -5, 0, 5));
		for (int i = 0; i < N_RANDOM; i++)
			pending_requests.push_back(random_request());
		total_requests = pending_requests.size();
	end

	// Idle and stall rates step through four phases as requests are sent.
	always_comb begin
		case ((sent_count * 4) / (total_requests + 1))
			0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1:       begin send_idle_pct = 67; recv_stall_pct = 0;  end
			2:       begin send_idle_pct = 0;  recv_stall_pct = 67; end
			default: begin send_idle_pct = 31; recv_stall_pct = 31; end
		endcase
	end

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		request_t q;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= 1'b0;
			sent_count <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				q = pending_requests.pop_front();
				expected_positions.push_back(resolve_position(q));
				s_tvalid   <= 1'b1;
				s_tdata    <= {1'b0, q.bz, q.bx, q.az, q.ax, q.rad, q.oz, q.ox};
				s_tuser    <= q.op;
				sent_count <= sent_count + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		position_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_tvalid && m_tready) begin
				received_count <= received_count + 1;
				if (m_tuser)
					moved_count <= moved_count + 1;
				if (expected_positions.size() == 0) begin
					mismatch_cnt <= mismatch_cnt + 1;
					if (mismatch_cnt < 10)
						$display("ERROR: unexpected result x=%h z=%h moved=%b",
							m_tdata[31:0], m_tdata[63:32], m_tuser);
				end else begin
					e = expected_positions.pop_front();
					if (m_tdata[31:0] !== e.nx || m_tdata[63:32] !== e.nz
							|| m_tuser !== e.moved) begin
						mismatch_cnt <= mismatch_cnt + 1;
						if (mismatch_cnt < 10)
							$display("ERROR: result %0d expected x=%h z=%h moved=%b, got x=%h z=%h moved=%b",
								received_count, e.nx, e.nz, e.moved,
								m_tdata[31:0], m_tdata[63:32], m_tuser);
					end
				end
			end
		end
	end

	// Reset, drain and final verdict.
	initial begin
		received_count = 0;
		moved_count    = 0;
		mismatch_cnt   = 0;
		arst_n         = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (total_requests > 0);
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || s_tvalid || expected_positions.size() != 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (expected_positions.size() != 0)
			mismatch_cnt = mismatch_cnt + expected_positions.size();
		$display("Sent %0d point and wall requests over four idle/stall phases.",
			sent_count);
		$display("Checked %0d results, %0d with the circle pushed; %0d mismatches.",
			received_count, moved_count, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("circle_collision_push_out test passed");
		else
			$display("circle_collision_push_out test failed");
		$finish;
	end

	// Watchdog.
	initial begin
		#2_000_000;
		$display("circle_collision_push_out test failed");
		$finish;
	end

endmodule
